// ===== rtl/assert_macros.svh =====
// Assertion macros used by the port-level checker of the offload policy block.
// Expects signals named clk and arst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define AOP_CHECK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define AOP_CHECK_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/aop_pkg.sv =====
// Shared types and constants of the adaptive offload policy block.
// No dependencies; used by the top level and the average update unit.
`timescale 1ns / 1ps

package aop_pkg;

	// Decision codes on the result channel
	localparam logic [1:0] DEC_OFFLOAD  = 2'd0;
	localparam logic [1:0] DEC_FALLBACK = 2'd1;
	localparam logic [1:0] DEC_REMOTE   = 2'd2;
	localparam logic [1:0] DEC_REPORT   = 2'd3;

	// Policy modes
	localparam logic [1:0] MODE_OFFLOAD  = 2'd0;
	localparam logic [1:0] MODE_FALLBACK = 2'd1;
	localparam logic [1:0] MODE_ADAPTIVE = 2'd2;

	// Register indexes (paddr[3:2])
	localparam logic [1:0] REG_MODE      = 2'd0;
	localparam logic [1:0] REG_THRESHOLD = 2'd1;
	localparam logic [1:0] REG_WEIGHT    = 2'd2;
	localparam logic [1:0] REG_INTERVAL  = 2'd3;

	// Reset values
	localparam logic [15:0] THRESHOLD_RST = 16'd19661;
	localparam logic [15:0] WEIGHT_RST    = 16'd13107;
	localparam logic [7:0]  INTERVAL_RST  = 8'd10;
	localparam logic [15:0] AVERAGE_RST   = 16'd43254;

	localparam logic [7:0]  STREAK_MAX    = 8'd255;
	localparam logic [15:0] SAMPLE_MAX    = 16'hFFFF;

	// Result of one average update
	typedef struct packed {
		logic        done;
		logic        update;
		logic [15:0] avg;
	} ema_res_t;

endpackage

// ===== rtl/adaptive_offload_policy_core.sv =====
// Top level of the adaptive offload policy block: handshake, registers, decision.
// Depends on aop_pkg and aop_ema_unit.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one item per dispatch request
//   (kind 0) or completion report (kind 1). Every item yields exactly one
//   result on the output channel (out_valid/out_stall) with the decision and
//   the block's counters and average after the item.
//   A dispatch goes from acceptance straight to the output load; a report
//   runs 16 restoring divide steps for the sparsity ratio, one multiply, one
//   blend, one handoff and one output load, skipping the divide steps if the
//   ratio saturates and all but the handoff and load with no ops. One item
//   at a time: no new item is taken until the last one reaches its load.
//   The block takes the next item while a finished result still waits in the
//   output register; if the receiver stalls, the following result waits in
//   its finish step and the payload shown on the outputs holds.
//   Reset clears the counters and streak, loads the average with 0.66 and
//   the registers with their defaults; no clearing pass is needed.
//   The user must write registers over the APB port only while the block is idle; the block does not enforce it.
`timescale 1ns / 1ps

module adaptive_offload_policy_core (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input items
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        kind,
	input  logic        is_remote,
	input  logic [31:0] skip_count,
	input  logic [31:0] op_count,
	// result items
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  decision,
	output logic [15:0] sparsity_average,
	output logic [63:0] offloaded_total,
	output logic [63:0] fallback_total,
	output logic [7:0]  streak_now
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_RUN,
		S_FIN
	} state_t;

	state_t      state_q;
	logic        kind_q;
	logic        remote_q;

	logic [1:0]  mode_q;
	logic [15:0] thr_q;
	logic [15:0] wgt_q;
	logic [7:0]  intv_q;

	logic [15:0] avg_q;
	logic [63:0] off_cnt_q;
	logic [63:0] fb_cnt_q;
	logic [7:0]  streak_q;

	logic        out_valid_q;
	logic [1:0]  dec_q;
	logic [15:0] avg_out_q;
	logic [63:0] off_out_q;
	logic [63:0] fb_out_q;
	logic [7:0]  streak_out_q;

	logic              accept;
	logic              start;
	logic              cfg_wr;
	logic              out_free;
	logic              offload;
	logic [1:0]        dec_n;
	logic [63:0]       off_n;
	logic [63:0]       fb_n;
	logic [7:0]        streak_n;
	aop_pkg::ema_res_t ema_res;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign start    = accept && kind;
	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite;
	assign out_free = !out_valid_q || !out_stall;

	aop_ema_unit u_ema (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.skip_count (skip_count),
		.op_count   (op_count),
		.avg        (avg_q),
		.weight     (wgt_q),
		.res        (ema_res)
	);

	// Register read
	always_comb begin
		unique case (paddr[3:2])
			aop_pkg::REG_MODE:      prdata = {30'd0, mode_q};
			aop_pkg::REG_THRESHOLD: prdata = {16'd0, thr_q};
			aop_pkg::REG_WEIGHT:    prdata = {16'd0, wgt_q};
			aop_pkg::REG_INTERVAL:  prdata = {24'd0, intv_q};
			default:                prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= aop_pkg::MODE_OFFLOAD;
			thr_q  <= aop_pkg::THRESHOLD_RST;
			wgt_q  <= aop_pkg::WEIGHT_RST;
			intv_q <= aop_pkg::INTERVAL_RST;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				aop_pkg::REG_MODE:      mode_q <= pwdata[1:0];
				aop_pkg::REG_THRESHOLD: thr_q  <= pwdata[15:0];
				aop_pkg::REG_WEIGHT:    wgt_q  <= pwdata[15:0];
				aop_pkg::REG_INTERVAL:  intv_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// Decision and next counters for the item in the finish step
	always_comb begin
		case (mode_q)
			aop_pkg::MODE_FALLBACK: offload = 1'b0;
			aop_pkg::MODE_ADAPTIVE: offload = (avg_q >= thr_q) || (streak_q >= intv_q);
			default:                offload = 1'b1;
		endcase
		off_n    = off_cnt_q;
		fb_n     = fb_cnt_q;
		streak_n = streak_q;
		if (kind_q) begin
			dec_n = aop_pkg::DEC_REPORT;
		end else if (remote_q) begin
			dec_n = aop_pkg::DEC_REMOTE;
		end else if (offload) begin
			dec_n    = aop_pkg::DEC_OFFLOAD;
			off_n    = off_cnt_q + 64'd1;
			streak_n = '0;
		end else begin
			dec_n = aop_pkg::DEC_FALLBACK;
			fb_n  = fb_cnt_q + 64'd1;
			if (streak_q != aop_pkg::STREAK_MAX) begin
				streak_n = streak_q + 8'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			avg_q       <= aop_pkg::AVERAGE_RST;
			off_cnt_q   <= '0;
			fb_cnt_q    <= '0;
			streak_q    <= '0;
		end else begin
			// raise on a load, drop once the receiver takes the item
			if (state_q == S_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						kind_q   <= kind;
						remote_q <= is_remote;
						state_q  <= kind ? S_RUN : S_FIN;
					end
				end
				S_RUN: begin
					if (ema_res.done) begin
						if (ema_res.update) begin
							avg_q <= ema_res.avg;
						end
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					// hold until the output register is free
					if (out_free) begin
						off_cnt_q    <= off_n;
						fb_cnt_q     <= fb_n;
						streak_q     <= streak_n;
						dec_q        <= dec_n;
						avg_out_q    <= avg_q;
						off_out_q    <= off_n;
						fb_out_q     <= fb_n;
						streak_out_q <= streak_n;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid        = out_valid_q;
	assign decision         = dec_q;
	assign sparsity_average = avg_out_q;
	assign offloaded_total  = off_out_q;
	assign fallback_total   = fb_out_q;
	assign streak_now       = streak_out_q;

endmodule

// ===== rtl/aop_ema_unit.sv =====
// Average update unit: serial ratio divider followed by one weighted blend.
// Depends on aop_pkg for the result struct and constants.
`timescale 1ns / 1ps

module aop_ema_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [31:0]          skip_count,
	input  logic [31:0]          op_count,
	input  logic [15:0]          avg,
	input  logic [15:0]          weight,
	output aop_pkg::ema_res_t    res
);

	typedef enum logic [1:0] {
		U_IDLE,
		U_DIV,
		U_MUL,
		U_SUM
	} ustate_t;

	ustate_t           state_q;
	logic [31:0]       rem_q;
	logic [31:0]       tot_q;
	logic [15:0]       quo_q;
	logic [3:0]        cnt_q;
	logic signed [33:0] prod_q;
	aop_pkg::ema_res_t res_q;

	logic [32:0]        shifted;
	logic [32:0]        trial;
	logic               ge;
	logic signed [16:0] diff;
	logic signed [16:0] wgt;
	logic signed [34:0] sum;

	always_comb begin
		shifted = {rem_q, 1'b0};
		trial   = shifted - {1'b0, tot_q};
		ge      = shifted >= {1'b0, tot_q};
		diff    = signed'({1'b0, quo_q}) - signed'({1'b0, avg});
		wgt     = signed'({1'b0, weight});
		sum     = signed'({3'b000, avg, 16'h0000}) + {prod_q[33], prod_q}
			+ 35'sd32768;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= U_IDLE;
			res_q.done <= 1'b0;
			res_q.update <= 1'b0;
			res_q.avg  <= '0;
		end else begin
			unique case (state_q)
				U_IDLE: begin
					res_q.done <= start && (op_count == '0);
					if (start) begin
						tot_q <= op_count;
						rem_q <= skip_count;
						cnt_q <= '0;
						if (op_count == '0) begin
							// no ops: keep the average
							res_q.update <= 1'b0;
						end else if (skip_count >= op_count) begin
							quo_q   <= aop_pkg::SAMPLE_MAX;
							state_q <= U_MUL;
						end else begin
							state_q <= U_DIV;
						end
					end
				end
				U_DIV: begin
					// one quotient bit per cycle, restoring
					res_q.done <= 1'b0;
					quo_q <= {quo_q[14:0], ge};
					rem_q <= ge ? trial[31:0] : shifted[31:0];
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd15) begin
						state_q <= U_MUL;
					end
				end
				U_MUL: begin
					res_q.done <= 1'b0;
					prod_q  <= wgt * diff;
					state_q <= U_SUM;
				end
				U_SUM: begin
					// avg + w*(s - avg), rounded half up
					res_q.avg    <= sum[31:16];
					res_q.update <= 1'b1;
					res_q.done   <= 1'b1;
					state_q      <= U_IDLE;
				end
				default: begin
					res_q.done <= 1'b0;
					state_q <= U_IDLE;
				end
			endcase
		end
	end

	assign res = res_q;

endmodule

// ===== rtl/aop_checker.sv =====
// Port-level checker for the adaptive offload policy block, bound to the top level.
// Depends on assert_macros.svh and aop_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module aop_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  decision,
	input logic [15:0] sparsity_average,
	input logic [7:0]  streak_now
);

	// a stalled result holds
	`AOP_CHECK(a_out_hold, out_valid && out_stall |=> out_valid && $stable(decision) && $stable(sparsity_average), "stalled result changed")

	// one item at a time: busy right after an accept
	`AOP_CHECK(a_busy_after_accept, in_valid && !in_stall |=> in_stall, "item accepted while busy")

	// an offload clears the streak, a fallback leaves it nonzero
	`AOP_CHECK(a_streak_offload, out_valid && decision == aop_pkg::DEC_OFFLOAD |-> streak_now == 8'd0, "offload with nonzero streak")
	`AOP_CHECK(a_streak_fallback, out_valid && decision == aop_pkg::DEC_FALLBACK |-> streak_now != 8'd0, "fallback with zero streak")

	// no result during reset
	`AOP_CHECK_ALWAYS(a_reset_idle, !arst_n |-> !out_valid, "result valid in reset")

endmodule

bind adaptive_offload_policy_core aop_checker u_aop_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (in_valid),
	.in_stall         (in_stall),
	.out_valid        (out_valid),
	.out_stall        (out_stall),
	.decision         (decision),
	.sparsity_average (sparsity_average),
	.streak_now       (streak_now)
);

// ===== dv/offload_policy_checker.sv =====
// Checker for the adaptive offload policy core: tracks register writes, predicts
// each result item from accepted input items and compares it field by field.
// Depends on aop_pkg for decision codes, policy modes, register indexes and reset values.
`timescale 1ns / 1ps

module offload_policy_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic [31:0] prdata,
	input  logic        pready,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic        kind,
	input  logic        is_remote,
	input  logic [31:0] skip_count,
	input  logic [31:0] op_count,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [1:0]  decision,
	input  logic [15:0] sparsity_average,
	input  logic [63:0] offloaded_total,
	input  logic [63:0] fallback_total,
	input  logic [7:0]  streak_now,
	output int          mismatches,
	output int          pending,
	output int          checked
);

	typedef struct packed {
		logic [1:0]  decision;
		logic [15:0] average;
		logic [63:0] offloads;
		logic [63:0] fallbacks;
		logic [7:0]  streak;
	} policy_result_t;

	// register copies
	logic [1:0]  mode_r;
	logic [15:0] threshold_r;
	logic [15:0] weight_r;
	logic [7:0]  interval_r;

	// policy state
	logic [15:0] average_r;
	logic [63:0] offloads_r;
	logic [63:0] fallbacks_r;
	logic [7:0]  streak_r;

	policy_result_t pending_results[$];

	function automatic logic [15:0] blend_average(input logic [31:0] skips, input logic [31:0] ops);
		logic [15:0] sample;
		logic [63:0] acc;
		if (ops == '0)
			return average_r;
		// saturate the ratio at one
		if (skips >= ops)
			sample = aop_pkg::SAMPLE_MAX;
		else
			sample = 16'({skips, 16'h0000} / {16'h0000, ops});
		acc = 64'(17'h10000 - {1'b0, weight_r}) * 64'(average_r)
			+ 64'(weight_r) * 64'(sample) + 64'd32768;
		return acc[31:16];
	endfunction

	function automatic policy_result_t predict_decision(input logic k, input logic remote,
			input logic [31:0] skips, input logic [31:0] ops);
		policy_result_t res;
		logic offload;
		if (k) begin
			average_r = blend_average(skips, ops);
			res.decision = aop_pkg::DEC_REPORT;
		end else if (remote) begin
			res.decision = aop_pkg::DEC_REMOTE;
		end else begin
			if (mode_r == aop_pkg::MODE_FALLBACK)
				offload = 1'b0;
			else if (mode_r == aop_pkg::MODE_ADAPTIVE && average_r < threshold_r)
				offload = (streak_r >= interval_r);	// probe once the streak is long enough
			else
				offload = 1'b1;
			if (offload) begin
				offloads_r = offloads_r + 64'd1;
				streak_r = '0;
				res.decision = aop_pkg::DEC_OFFLOAD;
			end else begin
				fallbacks_r = fallbacks_r + 64'd1;
				if (streak_r != aop_pkg::STREAK_MAX)
					streak_r = streak_r + 8'd1;
				res.decision = aop_pkg::DEC_FALLBACK;
			end
		end
		res.average = average_r;
		res.offloads = offloads_r;
		res.fallbacks = fallbacks_r;
		res.streak = streak_r;
		return res;
	endfunction

	function automatic void check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		policy_result_t want;
		logic [31:0] read_want;
		if (!arst_n) begin
			mode_r = aop_pkg::MODE_OFFLOAD;
			threshold_r = aop_pkg::THRESHOLD_RST;
			weight_r = aop_pkg::WEIGHT_RST;
			interval_r = aop_pkg::INTERVAL_RST;
			average_r = aop_pkg::AVERAGE_RST;
			offloads_r = '0;
			fallbacks_r = '0;
			streak_r = '0;
			pending_results.delete();
			pending = 0;
		end else begin
			if (psel && penable && pready) begin
				if (pwrite) begin
					case (paddr[3:2])
						aop_pkg::REG_MODE:      mode_r = pwdata[1:0];
						aop_pkg::REG_THRESHOLD: threshold_r = pwdata[15:0];
						aop_pkg::REG_WEIGHT:    weight_r = pwdata[15:0];
						aop_pkg::REG_INTERVAL:  interval_r = pwdata[7:0];
						default: ;
					endcase
				end else begin
					case (paddr[3:2])
						aop_pkg::REG_MODE:      read_want = {30'b0, mode_r};
						aop_pkg::REG_THRESHOLD: read_want = {16'b0, threshold_r};
						aop_pkg::REG_WEIGHT:    read_want = {16'b0, weight_r};
						default:                read_want = {24'b0, interval_r};
					endcase
					check_field("prdata", read_want, prdata);
				end
			end
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					$error("result item arrived with no item outstanding");
					mismatches++;
				end else begin
					want = pending_results.pop_front();
					check_field("decision", want.decision, decision);
					check_field("sparsity_average", want.average, sparsity_average);
					check_field("offloaded_total", want.offloads, offloaded_total);
					check_field("fallback_total", want.fallbacks, fallback_total);
					check_field("streak_now", want.streak, streak_now);
					checked++;
				end
			end
			if (in_valid && !in_stall)
				pending_results.push_back(predict_decision(kind, is_remote, skip_count,
					op_count));
			pending = pending_results.size();
		end
	end

endmodule

// ===== dv/adaptive_offload_policy_core_test.sv =====
// Top of the offload policy testbench: clock, reset, register setup and item
// traffic with random gaps and stalls; verdict from offload_policy_checker.
// Depends on aop_pkg, adaptive_offload_policy_core and offload_policy_checker.
`timescale 1ns / 1ps

module adaptive_offload_policy_core_test;

	localparam logic [1:0] MODE_UNDEFINED = 2'd3;
	localparam int IDLE_LIMIT = 2000;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS = 155;
	localparam int STREAK_ITEMS = 300;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid;
	logic        in_stall;
	logic        kind;
	logic        is_remote;
	logic [31:0] skip_count;
	logic [31:0] op_count;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  decision;
	logic [15:0] sparsity_average;
	logic [63:0] offloaded_total;
	logic [63:0] fallback_total;
	logic [7:0]  streak_now;

	int mismatches;
	int pending;
	int checked;
	int idle_cycles = 0;
	int dispatches = 0;
	int reports = 0;
	int settings = 0;
	bit steady = 1'b0;

	adaptive_offload_policy_core u_dut (.*);
	offload_policy_checker u_check (.*);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// result side: stall a random number of cycles ahead of each item
	initial begin
		int hold;
		out_stall <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			hold = steady ? 0 : $urandom_range(0, 6);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (!out_valid);
		end
	end

	// drop valid so the last item is not taken again while draining
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	task automatic reg_access(input bit write_en, input logic [1:0] idx, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= write_en;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_policy(input logic [1:0] mode, input logic [15:0] thr,
			input logic [15:0] weight, input logic [7:0] intv);
		wait_drained();
		reg_access(1'b1, aop_pkg::REG_MODE, {30'b0, mode});
		reg_access(1'b1, aop_pkg::REG_THRESHOLD, {16'b0, thr});
		reg_access(1'b1, aop_pkg::REG_WEIGHT, {16'b0, weight});
		reg_access(1'b1, aop_pkg::REG_INTERVAL, {24'b0, intv});
		reg_access(1'b0, aop_pkg::REG_MODE, '0);
		reg_access(1'b0, aop_pkg::REG_THRESHOLD, '0);
		reg_access(1'b0, aop_pkg::REG_WEIGHT, '0);
		reg_access(1'b0, aop_pkg::REG_INTERVAL, '0);
		settings++;
	endtask

	task automatic send_item(input logic k, input logic remote, input logic [31:0] skips,
			input logic [31:0] ops);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		is_remote <= remote;
		skip_count <= skips;
		op_count <= ops;
		do @(posedge clk); while (in_stall);
		if (k)
			reports++;
		else
			dispatches++;
	endtask

	function automatic logic [15:0] pick_q16();
		case ($urandom_range(0, 5))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		logic [31:0] skips;
		logic [31:0] ops;
		logic [1:0] mode;
		logic [7:0] intv;
		int items;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_valid <= 1'b0;
		kind <= 1'b0;
		is_remote <= 1'b0;
		skip_count <= '0;
		op_count <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// reset policy: offload all
		send_item(1'b0, 1'b0, '0, '0);
		send_item(1'b0, 1'b1, '1, '1);
		send_item(1'b1, 1'b0, '0, '0);				// report with no ops
		send_item(1'b1, 1'b1, 32'hFFFF_FFFF, 32'd1);	// ratio far above one
		send_item(1'b1, 1'b0, 32'd5, 32'd5);		// ratio exactly one
		send_item(1'b1, 1'b0, '0, '1);
		send_item(1'b1, 1'b0, 32'h7FFF_FFFF, '1);
		send_item(1'b0, 1'b0, '1, '1);

		// adaptive: three fallbacks, a probe, then fallback again
		set_policy(aop_pkg::MODE_ADAPTIVE, 16'hFFFF, 16'hFFFF, 8'd3);
		repeat (5) send_item(1'b0, 1'b0, '0, '0);
		send_item(1'b0, 1'b1, '0, '0);
		// full weight pulls the average to the top, no longer below threshold
		send_item(1'b1, 1'b0, '1, '1);
		send_item(1'b0, 1'b0, '0, '0);

		set_policy(aop_pkg::MODE_FALLBACK, aop_pkg::THRESHOLD_RST, 16'h0000, 8'd255);
		send_item(1'b0, 1'b0, '0, '0);
		send_item(1'b1, 1'b0, 32'd3, 32'd4);		// zero weight holds the average

		set_policy(MODE_UNDEFINED, 16'h0000, aop_pkg::WEIGHT_RST, aop_pkg::INTERVAL_RST);
		send_item(1'b0, 1'b0, '0, '0);

		// zero interval: every low-sparsity dispatch probes
		set_policy(aop_pkg::MODE_ADAPTIVE, 16'hFFFF, aop_pkg::WEIGHT_RST, 8'd0);
		repeat (2) send_item(1'b0, 1'b0, '0, '0);

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			steady = (p == 1) || ($urandom_range(0, 4) == 0);
			case ($urandom_range(0, 9))
				0:       mode = MODE_UNDEFINED;
				1, 2:    mode = aop_pkg::MODE_OFFLOAD;
				3, 4:    mode = aop_pkg::MODE_FALLBACK;
				default: mode = aop_pkg::MODE_ADAPTIVE;
			endcase
			intv = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
				: 8'($urandom_range(1, 16));
			items = PHASE_ITEMS;
			if (p == 3) begin
				// long fallback run to saturate the streak
				set_policy(aop_pkg::MODE_FALLBACK, pick_q16(), pick_q16(), intv);
				items = STREAK_ITEMS;
			end else if (p == 4) begin
				set_policy(aop_pkg::MODE_ADAPTIVE, 16'hFFFF, pick_q16(), 8'd255);
			end else begin
				set_policy(mode, pick_q16(), pick_q16(), intv);
			end
			for (int n = 0; n < items; n++) begin
				// halfway through the phase, hold the sender until every result is back
				if (n == items / 2)
					wait_drained();
				if (p == 3 || $urandom_range(0, 99) < 60) begin
					send_item(1'b0, (p != 3) && ($urandom_range(0, 5) == 0), $urandom, $urandom);
				end else begin
					case ($urandom_range(0, 9))
						0: begin
							ops = '0;
							skips = $urandom;
						end
						1: begin
							ops = $urandom_range(1, 1000);
							skips = ops + $urandom_range(0, 1000);
						end
						2, 3: begin
							ops = $urandom;
							skips = $urandom;
						end
						default: begin
							ops = $urandom_range(1, 4096);
							skips = $urandom_range(0, ops);
						end
					endcase
					send_item(1'b1, 1'($urandom_range(0, 1)), skips, ops);
				end
			end
		end
		steady = 1'b0;

		wait_drained();
		repeat (25) @(posedge clk);
		@(negedge clk);
		$display("Sent %0d dispatches and %0d completion reports under %0d register settings.",
			dispatches, reports, settings);
		$display("Compared %0d result items against the policy prediction.", checked);
		if (mismatches == 0 && pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
